[design/bm3_pkg.sv]
// shared types, constants and helpers of the 3x3 binary morphology block
`default_nettype none

package bm3_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  localparam int unsigned CFG_DW = 12;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned PIX_W  = 8;

  localparam logic [CFG_IW-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  localparam logic [CFG_DW-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_DW-1:0] RESET_HEIGHT = 12'd480;

  // per-cell controls of the window column chain
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       sel_post;
    logic [2:0] row_en;
  } bm3_cell_ctl_t;

  // frame dimension held to 2..maxv
  function automatic logic [31:0] clamp_dim(input logic [CFG_DW-1:0] v,
                                            input int unsigned maxv);
    logic [31:0] x;
    logic [31:0] res;
    x = 32'(v);
    if (x < 32'd2) begin
      res = 32'd2;
    end else if (x > maxv) begin
      res = maxv;
    end else begin
      res = x;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/bm3_in_if.sv]
// source pixel channel: valid/ready handshake with drain flag and pixel
`default_nettype none

interface bm3_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [bm3_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output func, output pixel_value, input ready);
  modport sink   (input valid, input func, input pixel_value, output ready);
endinterface

`default_nettype wire

[design/bm3_out_if.sv]
// result pixel channel: valid/ready handshake with pixel and end of frame flag
`default_nettype none

interface bm3_out_if;
  logic                      valid;
  logic                      ready;
  logic [bm3_pkg::PIX_W-1:0] result_pixel;
  logic                      frame_last;

  modport source (output valid, output result_pixel, output frame_last, input ready);
  modport sink   (input valid, input result_pixel, input frame_last, output ready);
endinterface

`default_nettype wire

[design/binary_morphology_3x3.sv]
// Streaming 3x3 binary erosion / dilation over a raster pixel stream.
// in_ch carries one word per pixel (func pixel) or a drain word (func drain);
// out_ch gives one 0/255 word per source pixel in raster order, frame_last on
// the bottom right pixel. cfg_we/cfg_index/cfg_wdata write mode, width, height;
// a width or height write restarts the frame. Write only while idle.
// Throughput: one input word per cycle while in_ch.ready is high, set by the
// line buffer (one write and one registered read a cycle, the read prefetched
// one word ahead) and by the three-cell window chain.
// The result for pixel (r,c) is computed when pixel (r+1,c+1) is taken (row ends:
// the first pixel of row r+2) and registered in the output register, or the skid
// stage while out_ch stalls. After the last pixel of a frame, width+1 drain words
// flush the remaining results; drains before that and pixels during it give nothing.
// Reset clears counters, window and output stage and loads mode erode,
// 640x480. The line buffer is not cleared: stale flags only reach window rows
// that border clipping removes, so no clearing pass is needed.
// Receiver stall: an output register plus a one-word skid stage; in_ch.ready
// drops only while the skid stage holds a word.
`default_nettype none

module binary_morphology_3x3 #(
  parameter int unsigned MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bm3_in_if.sink                          in_ch,
  bm3_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [bm3_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [bm3_pkg::CFG_DW-1:0] cfg_wdata
);
  import bm3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration
  logic          mode_r;
  logic [CW-1:0] w_r, w_m1_r;
  logic [RW-1:0] h_r, h_m1_r;
  logic [31:0]   cfg_w_clamp, cfg_h_clamp, rst_w_clamp, rst_h_clamp;

  assign cfg_w_clamp = clamp_dim(cfg_wdata, MAX_WIDTH);
  assign cfg_h_clamp = clamp_dim(cfg_wdata, MAX_HEIGHT);
  assign rst_w_clamp = clamp_dim(RESET_WIDTH, MAX_WIDTH);
  assign rst_h_clamp = clamp_dim(RESET_HEIGHT, MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ERODE;
      w_r    <= CW'(rst_w_clamp);
      w_m1_r <= CW'(rst_w_clamp - 32'd1);
      h_r    <= RW'(rst_h_clamp);
      h_m1_r <= RW'(rst_h_clamp - 32'd1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: begin
          mode_r <= cfg_wdata[0];
        end
        REG_WIDTH: begin
          w_r    <= CW'(cfg_w_clamp);
          w_m1_r <= CW'(cfg_w_clamp - 32'd1);
        end
        REG_HEIGHT: begin
          h_r    <= RW'(cfg_h_clamp);
          h_m1_r <= RW'(cfg_h_clamp - 32'd1);
        end
        default: begin
        end
      endcase
    end
  end

  // input side decode
  logic          in_acc, is_drain, frame_in, pix_ok, drn_ok, col0, colw;
  logic          emit_pre, emit_post, emit, shift, restart, cfg_restart;
  logic [1:0]    rd_data;
  logic [2:0]    new_col;
  logic          z_flag;
  logic          skid_valid_r;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;

  assign in_ch.ready = ~skid_valid_r;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign is_drain    = (in_ch.func == FUNC_DRAIN);
  assign frame_in    = (in_row_r < h_r);
  assign col0        = (in_col_r == '0);
  assign colw        = (in_col_r == w_r);
  assign pix_ok      = in_acc & ~is_drain & frame_in & (in_col_r < w_r);
  assign drn_ok      = in_acc & is_drain & ~frame_in;
  assign cfg_restart = cfg_we & ((cfg_index == REG_WIDTH) | (cfg_index == REG_HEIGHT));

  assign emit_pre  = (pix_ok & col0 & (in_row_r >= RW'(2))) | (drn_ok & (col0 | colw));
  assign emit_post = (pix_ok & ~col0 & (in_row_r != '0)) | (drn_ok & ~col0 & ~colw);
  assign emit      = emit_pre | emit_post;
  assign shift     = pix_ok | (drn_ok & ~colw);
  assign restart   = cfg_restart | (drn_ok & colw);

  assign z_flag  = pix_ok & (in_ch.pixel_value == PIX_BLACK);
  // column bits: 0 oldest row, 2 newest row
  assign new_col = {z_flag, rd_data[0], rd_data[1]};

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (pix_ok) begin
      if (in_col_r == w_m1_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end else if (drn_ok) begin
      in_col_nxt = in_col_r + CW'(1);
    end
  end

  always_comb begin
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart) begin
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (emit) begin
      if (out_col_r == w_m1_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + RW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // line buffer, read prefetched at the next column
  bm3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk   (clk),
    .we    (pix_ok),
    .waddr (in_col_r[AW-1:0]),
    .wdata ({rd_data[0], z_flag}),
    .raddr (in_col_nxt[AW-1:0]),
    .rdata (rd_data)
  );

  // window: chain of three column cells, newest column enters cell 2
  bm3_cell_ctl_t cell_ctl;
  logic [2:0]    cell_col_en;
  logic [2:0]    col_link [4];
  logic [3:0]    and_chain;
  logic [3:0]    or_chain;

  assign cell_ctl.shift     = shift;
  assign cell_ctl.clear     = restart;
  assign cell_ctl.sel_post  = emit_post;
  assign cell_ctl.row_en[0] = (out_row_r != '0);
  assign cell_ctl.row_en[1] = 1'b1;
  assign cell_ctl.row_en[2] = (out_row_r != h_m1_r);

  // left column is clipped at both borders: at the right one the center sits in cell 2
  assign cell_col_en[0] = (out_col_r != '0) & (out_col_r != w_m1_r);
  assign cell_col_en[1] = 1'b1;
  assign cell_col_en[2] = 1'b1;

  assign col_link[3] = new_col;
  assign and_chain[0] = 1'b1;
  assign or_chain[0]  = 1'b0;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    bm3_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .col_en  (cell_col_en[k]),
      .col_in  (col_link[k+1]),
      .and_in  (and_chain[k]),
      .or_in   (or_chain[k]),
      .col_out (col_link[k]),
      .and_out (and_chain[k+1]),
      .or_out  (or_chain[k+1])
    );
  end

  logic             res_black;
  logic [PIX_W-1:0] res_pix;
  logic             res_last;

  assign res_black = (mode_r == MODE_DILATE) ? or_chain[3] : and_chain[3];
  assign res_pix   = res_black ? PIX_BLACK : PIX_WHITE;
  assign res_last  = (out_row_r == h_m1_r) & (out_col_r == w_m1_r);

  // output register with one-word skid
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r, skid_pix_r;
  logic             out_last_r, skid_last_r;
  logic             out_take;

  assign out_take = out_valid_r & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_pix_r    <= skid_pix_r;
        out_last_r   <= skid_last_r;
        skid_valid_r <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_r || out_take) begin
        out_pix_r   <= res_pix;
        out_last_r  <= res_last;
        out_valid_r <= 1'b1;
      end else begin
        skid_pix_r   <= res_pix;
        skid_last_r  <= res_last;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_pixel = out_pix_r;
  assign out_ch.frame_last   = out_last_r;

endmodule

`default_nettype wire

[design/bm3_linebuf.sv]
// two-row line buffer of zero flags, one write and one registered read per cycle
`default_nettype none

module bm3_linebuf #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [1:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [1:0]    rdata
);

  // bit 1: row two above, bit 0: row above
  logic [1:0] line_mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= line_mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

[design/bm3_cell.sv]
// one window column cell: holds three zero flags and extends the clipped reduction
`default_nettype none

module bm3_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bm3_pkg::bm3_cell_ctl_t ctl,
  input  wire logic                  col_en,
  input  wire logic [2:0]            col_in,
  input  wire logic                  and_in,
  input  wire logic                  or_in,
  output logic      [2:0]            col_out,
  output logic                       and_out,
  output logic                       or_out
);
  import bm3_pkg::*;

  logic [2:0] col_r;
  logic [2:0] col_nxt;
  logic [2:0] col_sel;
  logic       hit_all;
  logic       hit_any;

  always_comb begin
    col_nxt = col_r;
    if (ctl.clear) begin
      col_nxt = 3'b000;
    end else if (ctl.shift) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 3'b000;
    end else begin
      col_r <= col_nxt;
    end
  end

  // after-shift view is the column arriving from the neighbor
  assign col_sel = ctl.sel_post ? col_in : col_r;
  assign hit_all = &(col_sel | ~ctl.row_en);
  assign hit_any = |(col_sel & ctl.row_en);

  assign and_out = and_in & (~col_en | hit_all);
  assign or_out  = or_in | (col_en & hit_any);
  assign col_out = col_r;

endmodule

`default_nettype wire
